// ===== hdl/xsfu_pkg.sv =====
// Shared types and constants for the x86 status flag unit.
// No dependencies; every other file in hdl/ imports this package.
package xsfu_pkg;

  // Operation codes carried on req_type. Codes 14 and 15 are unused.
  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_ADC  = 4'd1,
    OP_SUB  = 4'd2,
    OP_INC  = 4'd3,
    OP_DEC  = 4'd4,
    OP_NEG  = 4'd5,
    OP_MUL  = 4'd6,
    OP_IMUL = 4'd7,
    OP_SHL  = 4'd8,
    OP_SHR  = 4'd9,
    OP_AND  = 4'd10,
    OP_OR   = 4'd11,
    OP_XOR  = 4'd12,
    OP_TEST = 4'd13
  } op_t;

  // Update mask bit positions and common mask values.
  localparam int unsigned MaskCf = 0;
  localparam int unsigned MaskPf = 1;
  localparam int unsigned MaskZf = 2;
  localparam int unsigned MaskSf = 3;
  localparam int unsigned MaskOf = 4;

  localparam logic [4:0] MASK_NONE  = 5'h00;
  localparam logic [4:0] MASK_ALL   = 5'h1F;
  localparam logic [4:0] MASK_NO_CF = 5'h1E;
  localparam logic [4:0] MASK_CF_OF = 5'h11;
  localparam logic [4:0] MASK_SHIFT = 5'h0F;

  // Operand widths in bits for byte and word operations.
  localparam logic [4:0] BYTE_BITS = 5'd8;
  localparam logic [4:0] WORD_BITS = 5'd16;

  // One input item as held in the input register.
  typedef struct packed {
    logic [3:0]  req_type;
    logic        word_width;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic        carry_in;
    logic [7:0]  shift_count;
  } item_t;

  // One result item as held in the result register.
  typedef struct packed {
    logic       carry_out;
    logic       parity_even;
    logic       zero_result;
    logic       sign_bit;
    logic       overflow_out;
    logic [4:0] update_mask;
  } flags_t;

endpackage

// ===== hdl/xsfu_in_stage.sv =====
// Input register of the x86 status flag unit: captures one item per transfer.
// Depends on xsfu_pkg for item_t.
module xsfu_in_stage import xsfu_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  stage_valid,
  input  logic  stage_ready,
  output item_t stage_item
);

  logic  valid;
  item_t item;

  // The register frees up whenever its item moves on in the same cycle.
  assign in_ready = !valid || stage_ready;

  // Valid bit for the held item.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // Payload register; loads only on a transfer.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

  assign stage_valid = valid;
  assign stage_item  = item;

endmodule

// ===== hdl/xsfu_eval.sv =====
// Flag evaluation logic of the x86 status flag unit: one operation to CF, PF,
// ZF, SF, OF and the update mask. Purely combinational; depends on xsfu_pkg.
module xsfu_eval import xsfu_pkg::*; (
  input  item_t  item,
  output flags_t flags
);

  logic        wide;
  logic [15:0] vmask;
  logic [15:0] sign;
  logic [15:0] a;
  logic [15:0] b;
  logic [4:0]  bits;
  logic        is_imul;
  logic [16:0] ma;
  logic [16:0] mb;
  logic signed [33:0] prod;
  logic [16:0] sum;
  logic [16:0] diff;
  logic [31:0] shl_full;
  logic [16:0] shr_full;
  logic        shift_big;

  // Operands reduced to the operation width.
  assign wide  = item.word_width;
  assign vmask = wide ? 16'hFFFF : 16'h00FF;
  assign sign  = wide ? 16'h8000 : 16'h0080;
  assign bits  = wide ? WORD_BITS : BYTE_BITS;
  assign a     = item.operand_a & vmask;
  assign b     = item.operand_b & vmask;

  // One shared 17x17 signed multiplier: zero-extended for mul, sign-extended for imul.
  assign is_imul = (op_t'(item.req_type) == OP_IMUL);
  assign ma = wide ? {is_imul & a[15], a} : {{9{is_imul & a[7]}}, a[7:0]};
  assign mb = wide ? {is_imul & b[15], b} : {{9{is_imul & b[7]}}, b[7:0]};
  assign prod = $signed(ma) * $signed(mb);

  // Adder and subtractor; the borrow is in bit 16, the carry in bit 16 for words and bit 8 for bytes.
  assign sum  = {1'b0, a} + {1'b0, b} +
                {16'd0, (op_t'(item.req_type) == OP_ADC) & item.carry_in};
  assign diff = {1'b0, a} - {1'b0, b};

  // Shifters; counts above the width are handled as a separate case.
  assign shift_big = item.shift_count > {3'd0, bits};
  assign shl_full  = {16'd0, a} << item.shift_count[4:0];
  assign shr_full  = {a, 1'b0} >> item.shift_count[4:0];

  always_comb begin
    logic [15:0] r;
    logic        cf;
    logic        of;
    logic [4:0]  m;
    r  = 16'd0;
    cf = 1'b0;
    of = 1'b0;
    m  = MASK_NONE;
    case (op_t'(item.req_type))
      OP_ADD, OP_ADC: begin
        r  = sum[15:0] & vmask;
        cf = wide ? sum[16] : sum[8];
        of = |((a ^ r) & (b ^ r) & sign);
        m  = MASK_ALL;
      end
      OP_SUB: begin
        r  = diff[15:0] & vmask;
        cf = diff[16];
        of = |((a ^ b) & (a ^ r) & sign);
        m  = MASK_ALL;
      end
      OP_INC: begin
        r  = (a + 16'd1) & vmask;
        of = (r == sign);
        m  = MASK_NO_CF;
      end
      OP_DEC: begin
        r  = (a - 16'd1) & vmask;
        of = (a == sign);
        m  = MASK_NO_CF;
      end
      OP_NEG: begin
        r  = (16'd0 - a) & vmask;
        cf = (a != 16'd0);
        of = (a == sign);
        m  = MASK_ALL;
      end
      OP_MUL: begin
        // Upper half of the unsigned product is nonzero.
        cf = wide ? (prod[31:16] != 16'd0) : (prod[15:8] != 8'd0);
        of = cf;
        m  = MASK_CF_OF;
      end
      OP_IMUL: begin
        // Product does not fit the lower half as a sign-extended value.
        cf = wide ? !((prod[31:15] == '0) || (prod[31:15] == '1))
                  : !((prod[15:7] == '0) || (prod[15:7] == '1));
        of = cf;
        m  = MASK_CF_OF;
      end
      OP_SHL: begin
        if (item.shift_count != 8'd0) begin
          if (!shift_big) begin
            r  = shl_full[15:0] & vmask;
            cf = wide ? shl_full[16] : shl_full[8];
          end
          m = MASK_SHIFT;
          if (item.shift_count == 8'd1) begin
            of = (|(r & sign)) ^ cf;
            m  = MASK_ALL;
          end
        end
      end
      OP_SHR: begin
        if (item.shift_count != 8'd0) begin
          if (!shift_big) begin
            r  = shr_full[16:1];
            cf = shr_full[0];
          end
          m = MASK_SHIFT;
          if (item.shift_count == 8'd1) begin
            of = |(a & sign);
            m  = MASK_ALL;
          end
        end
      end
      OP_AND, OP_TEST: begin
        r = a & b;
        m = MASK_ALL;
      end
      OP_OR: begin
        r = a | b;
        m = MASK_ALL;
      end
      OP_XOR: begin
        r = a ^ b;
        m = MASK_ALL;
      end
      default: begin
        m = MASK_NONE;
      end
    endcase

    // Flags that the operation does not write read as zero.
    flags.carry_out    = m[MaskCf] & cf;
    flags.parity_even  = m[MaskPf] & ~(^r[7:0]);
    flags.zero_result  = m[MaskZf] & (r == 16'd0);
    flags.sign_bit     = m[MaskSf] & (|(r & sign));
    flags.overflow_out = m[MaskOf] & of;
    flags.update_mask  = m;
  end

endmodule

// ===== hdl/xsfu_out_stage.sv =====
// Result register of the x86 status flag unit: holds one finished result.
// Depends on xsfu_pkg for flags_t.
module xsfu_out_stage import xsfu_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   stage_valid,
  output logic   stage_ready,
  input  flags_t stage_flags,
  output logic   out_valid,
  input  logic   out_ready,
  output flags_t out_flags
);

  logic   valid;
  flags_t flags;

  // Take a new result when empty or when the current one transfers now.
  assign stage_ready = !valid || out_ready;

  // Valid bit for the held result.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (stage_ready) begin
      valid <= stage_valid;
    end
  end

  // Result payload; holds while the receiver stalls.
  always_ff @(posedge clk) begin
    if (stage_valid && stage_ready) begin
      flags <= stage_flags;
    end
  end

  assign out_valid = valid;
  assign out_flags = flags;

endmodule

// ===== hdl/x86_status_flag_unit_top.sv =====
// x86 status flag unit: evaluates 8086 CF, PF, ZF, SF and OF for one ALU
// operation per item, with a mask of the flags the operation writes.
//
// Input channel: in_valid/in_ready with req_type, word_width, operand_a,
// operand_b, carry_in and shift_count. Output channel: out_valid/out_ready
// with carry_out, parity_even, zero_result, sign_bit, overflow_out and
// update_mask. Flags not written by the operation are driven as zero.
//
// An item transferred into the input register has its flags evaluated in one
// pass of logic, and they are loaded into the result register when it can
// take them, and are visible on out_valid once loaded.
// Throughput is one item per cycle while the receiver keeps up, set by the
// single evaluation pass with its one 17x17 multiplier between the two registers.
//
// Reset (rst, synchronous, active high) empties both registers; no other state
// exists. When the receiver stalls, the result holds and the input register
// can still take one more item, so in_ready drops only when both are full.
// Depends on xsfu_pkg, xsfu_in_stage, xsfu_eval and xsfu_out_stage.
module x86_status_flag_unit_top import xsfu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  req_type,
  input  logic        word_width,
  input  logic [15:0] operand_a,
  input  logic [15:0] operand_b,
  input  logic        carry_in,
  input  logic [7:0]  shift_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        carry_out,
  output logic        parity_even,
  output logic        zero_result,
  output logic        sign_bit,
  output logic        overflow_out,
  output logic [4:0]  update_mask
);

  item_t  in_item;
  item_t  stage_item;
  logic   stage_valid;
  logic   stage_ready;
  flags_t stage_flags;
  flags_t out_flags;

  // Gather the input fields into one item.
  assign in_item.req_type    = req_type;
  assign in_item.word_width  = word_width;
  assign in_item.operand_a   = operand_a;
  assign in_item.operand_b   = operand_b;
  assign in_item.carry_in    = carry_in;
  assign in_item.shift_count = shift_count;

  xsfu_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .stage_valid (stage_valid),
    .stage_ready (stage_ready),
    .stage_item  (stage_item)
  );

  xsfu_eval u_eval (
    .item  (stage_item),
    .flags (stage_flags)
  );

  xsfu_out_stage u_out_stage (
    .clk         (clk),
    .rst         (rst),
    .stage_valid (stage_valid),
    .stage_ready (stage_ready),
    .stage_flags (stage_flags),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_flags   (out_flags)
  );

  // Spread the result onto its output ports.
  assign carry_out    = out_flags.carry_out;
  assign parity_even  = out_flags.parity_even;
  assign zero_result  = out_flags.zero_result;
  assign sign_bit     = out_flags.sign_bit;
  assign overflow_out = out_flags.overflow_out;
  assign update_mask  = out_flags.update_mask;

  // The input side stalls only when both registers are full and the receiver waits.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low while the result register can drain");

  // An accepted item reaches the result register when the receiver keeps up.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) ##1 out_ready |=> out_valid)
    else $error("accepted item did not reach the result register");

  // Flags outside the update mask are never reported as set.
  a_masked_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((!carry_out || update_mask[MaskCf]) &&
                   (!parity_even || update_mask[MaskPf]) &&
                   (!zero_result || update_mask[MaskZf]) &&
                   (!sign_bit || update_mask[MaskSf]) &&
                   (!overflow_out || update_mask[MaskOf])))
    else $error("flag set without its update mask bit");

  // Multiplies write CF and OF together, always with the same value.
  a_mul_cf_of: assert property (@(posedge clk) disable iff (rst)
    (out_valid && update_mask == MASK_CF_OF) |-> (carry_out == overflow_out))
    else $error("multiply CF and OF disagree");

endmodule

// ===== bench/xsfu_flag_checker.sv =====
`timescale 1ns / 100ps
// Flag checker for the x86 status flag unit: watches both channels, predicts
// the flags of every accepted operation and compares them in order.
// Depends on xsfu_pkg for the operation codes, mask constants and flags_t.
module xsfu_flag_checker import xsfu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [3:0]  req_type,
  input  logic        word_width,
  input  logic [15:0] operand_a,
  input  logic [15:0] operand_b,
  input  logic        carry_in,
  input  logic [7:0]  shift_count,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        carry_out,
  input  logic        parity_even,
  input  logic        zero_result,
  input  logic        sign_bit,
  input  logic        overflow_out,
  input  logic [4:0]  update_mask,
  output int          mismatch_count,
  output int          pending_count
);

  flags_t expected_flags[$];
  flags_t seen_flags;
  flags_t wanted_flags;
  int     error_tally = 0;

  // Computes the 8086 flags and the written-flag mask for one operation.
  function automatic flags_t predict_flags(input logic [3:0] op, input logic wide,
                                           input logic [15:0] a_in, input logic [15:0] b_in,
                                           input logic cin, input logic [7:0] cnt);
    int unsigned nbits;
    logic [15:0] vmask;
    logic [15:0] sgn;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] r;
    logic [31:0] full;
    logic        cf;
    logic        of;
    logic [4:0]  m;
    int          sa;
    int          sb;
    int          prod;
    flags_t      f;
    nbits = wide ? 16 : 8;
    vmask = wide ? 16'hFFFF : 16'h00FF;
    sgn   = wide ? 16'h8000 : 16'h0080;
    a = a_in & vmask;
    b = b_in & vmask;
    r = '0;
    cf = 1'b0;
    of = 1'b0;
    m = MASK_NONE;
    case (op)
      OP_ADD, OP_ADC: begin
        full = {16'd0, a} + {16'd0, b} + ((op == OP_ADC) ? {31'd0, cin} : 32'd0);
        r = full[15:0] & vmask;
        cf = full[nbits];
        of = |((a ^ r) & (b ^ r) & sgn);
        m = MASK_ALL;
      end
      OP_SUB: begin
        r = (a - b) & vmask;
        cf = a < b;
        of = |((a ^ b) & (a ^ r) & sgn);
        m = MASK_ALL;
      end
      OP_INC: begin
        r = (a + 16'd1) & vmask;
        of = r == sgn;
        m = MASK_NO_CF;
      end
      OP_DEC: begin
        r = (a - 16'd1) & vmask;
        of = a == sgn;
        m = MASK_NO_CF;
      end
      OP_NEG: begin
        r = (16'd0 - a) & vmask;
        cf = a != 16'd0;
        of = a == sgn;
        m = MASK_ALL;
      end
      OP_MUL: begin
        full = {16'd0, a} * {16'd0, b};
        cf = (full >> nbits) != 32'd0;
        of = cf;
        m = MASK_CF_OF;
      end
      OP_IMUL: begin
        // Operands are reinterpreted as signed at the operation width.
        sa = int'({16'd0, a ^ sgn}) - int'({16'd0, sgn});
        sb = int'({16'd0, b ^ sgn}) - int'({16'd0, sgn});
        prod = sa * sb;
        cf = (prod < -int'({16'd0, sgn})) || (prod > int'({16'd0, sgn}) - 1);
        of = cf;
        m = MASK_CF_OF;
      end
      OP_SHL, OP_SHR: begin
        // A zero count leaves every flag alone.
        if (cnt != 8'd0) begin
          if (cnt > nbits) begin
            r = '0;
            cf = 1'b0;
          end else if (op == OP_SHL) begin
            full = {16'd0, a} << cnt;
            r = full[15:0] & vmask;
            cf = full[nbits];
          end else begin
            r = a >> cnt;
            full = {16'd0, a} >> (cnt - 8'd1);
            cf = full[0];
          end
          m = MASK_SHIFT;
          // Only a single-bit shift defines OF.
          if (cnt == 8'd1) begin
            of = (op == OP_SHL) ? (|(r & sgn)) ^ cf : |(a & sgn);
            m = MASK_ALL;
          end
        end
      end
      OP_AND, OP_TEST: begin
        r = a & b;
        m = MASK_ALL;
      end
      OP_OR: begin
        r = a | b;
        m = MASK_ALL;
      end
      OP_XOR: begin
        r = a ^ b;
        m = MASK_ALL;
      end
      default: ;
    endcase
    f.carry_out    = m[MaskCf] & cf;
    f.parity_even  = m[MaskPf] & ~(^r[7:0]);
    f.zero_result  = m[MaskZf] & (r == 16'd0);
    f.sign_bit     = m[MaskSf] & (|(r & sgn));
    f.overflow_out = m[MaskOf] & of;
    f.update_mask  = m;
    return f;
  endfunction

  task automatic compare_field(input string field, input logic [4:0] wanted,
                               input logic [4:0] seen);
    if (wanted !== seen) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, wanted, seen);
      error_tally++;
    end
  endtask

  // Results are matched first so that an unexpected one is never paired with
  // an operation transferred at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        seen_flags = '{carry_out, parity_even, zero_result, sign_bit, overflow_out,
                       update_mask};
        if (expected_flags.size() == 0) begin
          $display("%0t: result with no operation outstanding, got %0h", $time, seen_flags);
          error_tally++;
        end else begin
          wanted_flags = expected_flags.pop_front();
          compare_field("carry_out", 5'(wanted_flags.carry_out), 5'(seen_flags.carry_out));
          compare_field("parity_even", 5'(wanted_flags.parity_even),
                        5'(seen_flags.parity_even));
          compare_field("zero_result", 5'(wanted_flags.zero_result),
                        5'(seen_flags.zero_result));
          compare_field("sign_bit", 5'(wanted_flags.sign_bit), 5'(seen_flags.sign_bit));
          compare_field("overflow_out", 5'(wanted_flags.overflow_out),
                        5'(seen_flags.overflow_out));
          compare_field("update_mask", wanted_flags.update_mask, seen_flags.update_mask);
        end
      end
      if (in_valid && in_ready) begin
        expected_flags.push_back(predict_flags(req_type, word_width, operand_a, operand_b,
                                               carry_in, shift_count));
      end
    end
    mismatch_count <= error_tally;
    pending_count <= expected_flags.size();
  end

endmodule

// ===== bench/x86_status_flag_unit_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the x86 status flag unit: drives operations and result
// back-pressure, and gives the verdict. Depends on xsfu_pkg, the unit's top
// level and xsfu_flag_checker, which does all prediction and comparison.
module x86_status_flag_unit_top_tb;
  import xsfu_pkg::*;

  localparam int RESET_CYCLES = 5;
  localparam int RANDOM_OPS = 825;
  localparam int DRAIN_POINT = 400;
  localparam int LONG_HOLD = 48;
  localparam int SETTLE_CYCLES = 10;
  localparam int CYCLE_LIMIT = 1000000;
  // Codes past the last operation; the unit must write no flags for them.
  localparam logic [3:0] OP_SPARE_LO = 4'd14;
  localparam logic [3:0] OP_SPARE_HI = 4'd15;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  req_type = '0;
  logic        word_width = 1'b0;
  logic [15:0] operand_a = '0;
  logic [15:0] operand_b = '0;
  logic        carry_in = 1'b0;
  logic [7:0]  shift_count = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        carry_out;
  logic        parity_even;
  logic        zero_result;
  logic        sign_bit;
  logic        overflow_out;
  logic [4:0]  update_mask;
  int          mismatch_count;
  int          pending_count;
  int          cycle_count = 0;

  x86_status_flag_unit_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .word_width(word_width),
    .operand_a(operand_a), .operand_b(operand_b),
    .carry_in(carry_in), .shift_count(shift_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .carry_out(carry_out), .parity_even(parity_even), .zero_result(zero_result),
    .sign_bit(sign_bit), .overflow_out(overflow_out), .update_mask(update_mask)
  );

  xsfu_flag_checker flag_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .word_width(word_width),
    .operand_a(operand_a), .operand_b(operand_b),
    .carry_in(carry_in), .shift_count(shift_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .carry_out(carry_out), .parity_even(parity_even), .zero_result(zero_result),
    .sign_bit(sign_bit), .overflow_out(overflow_out), .update_mask(update_mask),
    .mismatch_count(mismatch_count), .pending_count(pending_count)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Idle stretch length: mostly short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 14) return $urandom_range(1, 3);
    if (roll < 19) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  // Operand with a bias toward the sign and carry boundaries.
  function automatic logic [15:0] pick_operand();
    logic [15:0] v;
    v = 16'($urandom);
    case ($urandom_range(0, 9))
      0: v = 16'h0000;
      1: v = 16'hFFFF;
      2: v[7:0] = 8'h80;
      3: v[7:0] = 8'h7F;
      4: v = 16'h8000;
      5: v = 16'h7FFF;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] pick_count();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd1;
      8, 9: return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(2, 17));
    endcase
  endfunction

  // Offers one operation and returns at the edge where it is transferred.
  task automatic offer_op(input logic [3:0] op, input logic wide, input logic [15:0] a,
                          input logic [15:0] b, input logic cin, input logic [7:0] cnt);
    in_valid <= 1'b1;
    req_type <= op;
    word_width <= wide;
    operand_a <= a;
    operand_b <= b;
    carry_in <= cin;
    shift_count <= cnt;
    do @(posedge clk); while (!in_ready);
  endtask

  // Waits until every transferred operation has produced its flags.
  task automatic wait_drained();
    do @(posedge clk); while (pending_count != 0);
  endtask

  // Reset, directed cases, random operations and the verdict.
  initial begin
    logic [3:0] op_code;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Boundary cases, back to back while the receiver is still holding off.
    offer_op(OP_ADD, 1'b0, 16'h007F, 16'h0001, 1'b1, 8'd0);
    offer_op(OP_ADC, 1'b1, 16'hFFFF, 16'h0000, 1'b1, 8'd3);
    offer_op(OP_SUB, 1'b0, 16'h0080, 16'h0001, 1'b0, 8'd0);
    offer_op(OP_SUB, 1'b1, 16'h0000, 16'h0001, 1'b1, 8'd0);
    offer_op(OP_INC, 1'b0, 16'h007F, 16'hFFFF, 1'b1, 8'd0);
    offer_op(OP_DEC, 1'b1, 16'h8000, 16'h0000, 1'b0, 8'd0);
    offer_op(OP_NEG, 1'b0, 16'hFF80, 16'h0000, 1'b0, 8'd0);
    offer_op(OP_NEG, 1'b1, 16'h0000, 16'h0000, 1'b0, 8'd0);
    offer_op(OP_MUL, 1'b0, 16'h00FF, 16'h00FF, 1'b0, 8'd0);
    offer_op(OP_MUL, 1'b1, 16'h00FF, 16'h0100, 1'b0, 8'd0);
    offer_op(OP_IMUL, 1'b0, 16'h0080, 16'h00FF, 1'b0, 8'd0);
    offer_op(OP_IMUL, 1'b1, 16'hFFFF, 16'h8000, 1'b0, 8'd0);
    offer_op(OP_SHL, 1'b0, 16'h00FF, 16'h0000, 1'b1, 8'd0);
    offer_op(OP_SHL, 1'b0, 16'h0040, 16'h0000, 1'b0, 8'd1);
    offer_op(OP_SHR, 1'b1, 16'h8001, 16'h0000, 1'b0, 8'd1);
    offer_op(OP_SHL, 1'b1, 16'h0001, 16'h0000, 1'b0, 8'd16);
    offer_op(OP_SHR, 1'b0, 16'h00FF, 16'h0000, 1'b0, 8'd9);
    offer_op(OP_SHL, 1'b0, 16'h00FF, 16'h0000, 1'b0, 8'd255);
    offer_op(OP_AND, 1'b1, 16'hFFFF, 16'h0F0F, 1'b0, 8'd0);
    offer_op(OP_OR, 1'b0, 16'h0000, 16'h0000, 1'b1, 8'd0);
    offer_op(OP_XOR, 1'b1, 16'h5555, 16'h5555, 1'b0, 8'd0);
    offer_op(OP_TEST, 1'b1, 16'hFFFF, 16'h8000, 1'b1, 8'd0);
    offer_op(OP_SPARE_LO, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 8'd1);
    offer_op(OP_SPARE_HI, 1'b0, 16'h8000, 16'h0001, 1'b0, 8'd2);
    offer_op(OP_ADD, 1'b0, 16'hAB80, 16'hCD80, 1'b0, 8'd0);

    // Sender pause: nothing is offered until every result is back.
    in_valid <= 1'b0;
    wait_drained();

    for (int n = 0; n < RANDOM_OPS; n++) begin
      if ($urandom_range(0, 19) == 0)
        op_code = $urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI;
      else
        op_code = 4'($urandom_range(0, 13));
      offer_op(op_code, 1'($urandom_range(0, 1)), pick_operand(), pick_operand(),
               1'($urandom_range(0, 1)), pick_count());
      if (n == DRAIN_POINT) begin
        in_valid <= 1'b0;
        wait_drained();
      end else if ($urandom_range(0, 9) >= 6) begin
        in_valid <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0)
      $display("x86_status_flag_unit_top_tb: clean");
    else
      $display("x86_status_flag_unit_top_tb: errors");
    $finish;
  end

  // Result side back-pressure: one long hold-off at the start so that the
  // unit fills and stalls its input, then random stalls and steady runs.
  initial begin
    int hold_left;
    int steady_left;
    steady_left = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    hold_left = LONG_HOLD;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (steady_left > 0) begin
        out_ready <= 1'b1;
        steady_left--;
      end else begin
        out_ready <= 1'b1;
        case ($urandom_range(0, 9))
          0, 1, 2: hold_left = pick_gap();
          3: steady_left = $urandom_range(20, 120);
          default: ;
        endcase
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("x86_status_flag_unit_top_tb: errors");
      $finish;
    end
  end

endmodule
